// ===== rtl/core/rpc_pkg.sv =====
// Shared types and constants for the residual pixel classifier.
// Used by rpc_grey, rpc_classify, rpc_counters and residual_pixel_classifier.
`timescale 1ns / 1ps

package rpc_pkg;

	// Pixel and counter widths
	localparam int unsigned PIX_W   = 24;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned COUNT_W = 25;

	// Counters stop here
	localparam logic [COUNT_W-1:0] MAX_PIXELS = 25'd16777216;

	// Grey weights (channel2, channel1, channel0) and fade offset
	localparam logic [15:0] GREY_W2 = 16'd76;
	localparam logic [15:0] GREY_W1 = 16'd150;
	localparam logic [15:0] GREY_W0 = 16'd29;
	localparam logic [CHAN_W-1:0] FADE_BASE = 8'd127;

	// Stand-in for the moved pixel when no motion was found
	localparam logic [PIX_W-1:0] MAGENTA = 24'hFF00FF;

	// Per-pixel classification result
	typedef struct packed {
		logic [PIX_W-1:0] visual;
		logic             resid;
		logic             differ;
	} cls_t;

	// Counter events for one pixel
	typedef struct packed {
		logic start;
		logic differ;
		logic moved;
		logic resid;
	} evt_t;

	// Counter values after one pixel
	typedef struct packed {
		logic [COUNT_W-1:0] differ;
		logic [COUNT_W-1:0] moved;
		logic [COUNT_W-1:0] resid;
	} cnt_t;

endpackage

// ===== rtl/core/rpc_grey.sv =====
// Grey conversion of one pixel, each weighted channel divided by 255 on its own.
// Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_grey
	import rpc_pkg::*;
(
	input  logic [PIX_W-1:0]  pixel,
	output logic [CHAN_W-1:0] grey
);

	// x / 255 for x below 2^16: estimate from x * 257 / 65536, then one correction
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
		logic [16:0] s;
		logic [8:0]  q;
		logic [16:0] r;
		s = {1'b0, x} + {9'd0, x[15:8]};
		q = s[16:8];
		r = {1'b0, x} - (({8'd0, q} << 8) - {8'd0, q});
		if (r >= 17'd255) begin
			q = q + 9'd1;
		end
		return q[CHAN_W-1:0];
	endfunction

	logic [15:0] p0, p1, p2;
	logic [9:0]  sum;

	// Weighted channels
	assign p0 = 16'(pixel[7:0])   * GREY_W0;
	assign p1 = 16'(pixel[15:8])  * GREY_W1;
	assign p2 = 16'(pixel[23:16]) * GREY_W2;

	// Sum of quotients, clipped to 255
	assign sum  = 10'(div255(p2)) + 10'(div255(p1)) + 10'(div255(p0));
	assign grey = (sum > 10'd255) ? 8'd255 : sum[CHAN_W-1:0];

endmodule

// ===== rtl/core/rpc_classify.sv =====
// Match / residual decision and visual pixel for one pixel position.
// Depends on rpc_pkg and rpc_grey.
`timescale 1ns / 1ps

module rpc_classify
	import rpc_pkg::*;
(
	input  logic [PIX_W-1:0] first_pixel,
	input  logic [PIX_W-1:0] second_pixel,
	input  logic [PIX_W-1:0] shifted_pixel,
	input  logic             motion_found,
	output cls_t             cls
);

	logic [PIX_W-1:0]  moved;
	logic [CHAN_W-1:0] g_first, g_second, g_moved, g_fade, fade_v, g_red;
	logic              match, same;

	assign moved = motion_found ? shifted_pixel : MAGENTA;
	assign match = (moved == second_pixel);
	assign same  = (first_pixel == second_pixel);

	rpc_grey u_grey_first  (.pixel(first_pixel),  .grey(g_first));
	rpc_grey u_grey_second (.pixel(second_pixel), .grey(g_second));
	rpc_grey u_grey_moved  (.pixel(moved),        .grey(g_moved));

	// Faded grey comes from the moved pixel on a match, else from the first one
	assign g_fade   = match ? g_moved : g_first;
	assign fade_v   = FADE_BASE + {1'b0, g_fade[CHAN_W-1:1]};

	// Residual red channel: moved grey with motion, first grey without
	assign g_red = motion_found ? g_moved : g_first;

	// Final pick
	always_comb begin
		cls.differ = !same;
		if (match || (!motion_found && same)) begin
			cls.visual = {fade_v, fade_v, fade_v};
			cls.resid  = 1'b0;
		end else begin
			cls.visual = {g_red, g_second, 8'd0};
			cls.resid  = 1'b1;
		end
	end

endmodule

// ===== rtl/core/rpc_counters.sv =====
// Saturating differ / moved / residual counters with frame-start clear.
// Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_counters
	import rpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  evt_t evt,
	output cnt_t cnt_next
);

	cnt_t cnt_q;

	// Clear on frame start, then count up to MAX_PIXELS
	function automatic logic [COUNT_W-1:0] bump(
		input logic [COUNT_W-1:0] c,
		input logic               clr,
		input logic               inc
	);
		logic [COUNT_W-1:0] b;
		b = clr ? '0 : c;
		if (inc && (b < MAX_PIXELS)) begin
			b = b + 1'b1;
		end
		return b;
	endfunction

	assign cnt_next.differ = bump(cnt_q.differ, evt.start, evt.differ);
	assign cnt_next.moved  = bump(cnt_q.moved,  evt.start, evt.moved);
	assign cnt_next.resid  = bump(cnt_q.resid,  evt.start, evt.resid);

	// Counter state moves once per pixel handed to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv) begin
			cnt_q <= cnt_next;
		end
	end

endmodule

// ===== rtl/core/residual_pixel_classifier.sv =====
// Top level: input register, per-pixel classify and counters, result register.
// Depends on rpc_pkg, rpc_classify, rpc_grey and rpc_counters.
//
//  Channel | Direction | Handshake          | Contents
//  s_      | in        | s_tvalid/s_tready  | one pixel position with motion flags
//  m_      | out       | m_tvalid/m_tready  | visual pixel, residual flag, counts
//
// One pixel per cycle sustained while m_tready stays high; a word taken on s_ passes
// through the input register and the result register before it is shown on m_.
// Grey conversion, classification and counter update sit in the single logic stage
// between the input register and the result register.
// Reset clears the valid flags and all three counters.
// With m_tready low a full result register holds and s_tready stays high until the
// input register is also full.
`timescale 1ns / 1ps

module residual_pixel_classifier
	import rpc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [23:0] first_pixel, [47:24] second_pixel, [71:48] shifted_pixel,
	// [72] motion_found, [73] motion_nonzero, [79:74] zero
	input  logic [79:0]  s_tdata,
	// [0] frame_start
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [23:0] visual_pixel, [24] is_residual, [49:25] differ_count,
	// [74:50] moved_count, [99:75] residual_count, [103:100] zero
	output logic [103:0] m_tdata
);

	// Input register
	logic             valid_s1;
	logic [PIX_W-1:0] first_s1, second_s1, shifted_s1;
	logic             found_s1, nonzero_s1, start_s1;

	// Result register
	logic             valid_s2;
	logic [PIX_W-1:0] visual_s2;
	logic             resid_s2;
	cnt_t             cnt_s2;

	logic adv;
	cls_t cls;
	evt_t evt;
	cnt_t cnt_next;

	// Flow control
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			first_s1   <= s_tdata[23:0];
			second_s1  <= s_tdata[47:24];
			shifted_s1 <= s_tdata[71:48];
			found_s1   <= s_tdata[72];
			nonzero_s1 <= s_tdata[73];
			start_s1   <= s_tuser[0];
		end
	end

	// Classification
	rpc_classify u_classify (
		.first_pixel   (first_s1),
		.second_pixel  (second_s1),
		.shifted_pixel (shifted_s1),
		.motion_found  (found_s1),
		.cls           (cls)
	);

	// Counters
	assign evt.start  = start_s1;
	assign evt.differ = cls.differ;
	assign evt.moved  = found_s1 && nonzero_s1;
	assign evt.resid  = cls.resid;

	rpc_counters u_counters (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.evt      (evt),
		.cnt_next (cnt_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			visual_s2 <= cls.visual;
			resid_s2  <= cls.resid;
			cnt_s2    <= cnt_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, cnt_s2.resid, cnt_s2.moved, cnt_s2.differ, resid_s2, visual_s2};

`ifndef NO_ASSERTIONS
	// Counts never pass the saturation limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt_s2.differ <= MAX_PIXELS && cnt_s2.moved <= MAX_PIXELS &&
			cnt_s2.resid <= MAX_PIXELS))
		else $error("counter above MAX_PIXELS");

	// A residual word has a black channel0, a non-residual word is a faded grey
	a_visual_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (resid_s2 ? (visual_s2[7:0] == 8'd0) :
			(visual_s2[7:0] == visual_s2[15:8] && visual_s2[15:8] == visual_s2[23:16] &&
			visual_s2[7:0] >= FADE_BASE)))
		else $error("visual pixel does not fit its class");

	// A residual pixel always differs from something, so it is counted
	a_resid_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && resid_s2) |-> (cnt_s2.resid != '0))
		else $error("residual word with zero residual count");

	// Without a frame start the differ counter never goes down
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !start_s1) |=> (u_counters.cnt_q.differ >= $past(u_counters.cnt_q.differ)))
		else $error("differ counter decreased inside a frame");
`endif

endmodule
